@@ src/tpsch_pkg.sv @@
`default_nettype none
package tpsch_pkg;

	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_ENQUEUE = 2'd1;
	localparam logic [1:0] CMD_SWITCH  = 2'd2;

	localparam logic [1:0] LVL_APP     = 2'd0;
	localparam logic [1:0] LVL_GRAPHIC = 2'd1;
	localparam logic [1:0] LVL_DRIVER  = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_RESERVED = 3'd1;
	localparam logic [2:0] ST_UNKNOWN  = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_DISABLED = 3'd4;

	localparam logic [7:0] FIRST_ID = 8'd3;

	localparam logic [1:0] WALK_ENQ = 2'd0;
	localparam logic [1:0] WALK_REQ = 2'd1;
	localparam logic [1:0] WALK_POP = 2'd2;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_sts_t;

endpackage
`default_nettype wire

@@ src/tpsch_ram.sv @@
`default_nettype none
module tpsch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ src/tpsch_fifo.sv @@
`default_nettype none
module tpsch_fifo #(
	parameter int DEPTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tpsch_pkg::fifo_ctl_t ctl,
	input  wire logic [7:0]           push_data,
	output      logic [7:0]           head_data,
	output      tpsch_pkg::fifo_sts_t sts
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW:0]   tail_sum;
	logic [AW-1:0] tail;
	logic          do_push;

	assign tail_sum = {1'b0, head_q} + (AW + 1)'(count_q);
	assign tail = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : tail_sum[AW-1:0];
	assign sts.empty = (count_q == '0);
	assign sts.full = (count_q == DEPTH_C);
	assign do_push = ctl.push && !sts.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
		end else if (do_push) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.pop && !sts.empty) begin
			head_q <= (head_q == LAST) ? '0 : head_q + AW'(1);
			count_q <= count_q - CW'(1);
		end
	end

	tpsch_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (tail),
		.wdata (push_data),
		.raddr (head_q),
		.rdata (head_data)
	);

endmodule
`default_nettype wire

@@ src/three_level_priority_task_scheduler_core.sv @@
// Channel | Signals                                        | Direction
// input   | in_valid, in_ready, command, task_id,          | in
//         | task_level, yielding                           |
// output  | out_valid, out_ready, status, result_id        | out
// config  | cfg_we, cfg_wdata                              | in
// A create goes straight to the done state; an enqueue and a switch walk the table,
// which compares one table entry at a time through the table memory port,
// passing through the seek and compare states for each entry.
// Reset empties the queues and the table and enables switching; no clearing pass.
// A new transfer is taken only in the idle state; a result waiting in the output
// register holds the sequencer only when the next result is ready to leave.
`default_nettype none
module three_level_priority_task_scheduler_core #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] task_id,
	input  wire logic [1:0]  task_level,
	input  wire logic        yielding,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [2:0]  status,
	output      logic [7:0]  result_id,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_TASKS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEEK   = 3'd1;
	localparam logic [2:0] S_CMP    = 3'd2;
	localparam logic [2:0] S_SELECT = 3'd3;
	localparam logic [2:0] S_POPD   = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]           state_q;
	logic [1:0]           purpose_q;
	logic [7:0]           key_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        count_q;
	logic [7:0]           running_q;
	logic                 enable_q;
	logic [MAX_TASKS-1:0] mark_q;
	logic [1:0]           sel_q;
	logic [2:0]           pend_status_q;
	logic [7:0]           pend_id_q;
	logic                 out_valid_q;
	logic [2:0]           status_q;
	logic [7:0]           result_id_q;

	logic [9:0]           tbl_rdata;
	logic                 tbl_we;
	logic [1:0]           new_lvl;
	logic [7:0]           new_id;
	logic                 hit;
	logic [IW-1:0]        hit_idx;
	logic                 push_en;
	logic [1:0]           push_lvl;
	logic [7:0]           push_data;
	logic                 accept;

	tpsch_pkg::fifo_ctl_t fifo_ctl [3];
	tpsch_pkg::fifo_sts_t fifo_sts [3];
	logic [7:0]           fifo_head [3];

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign result_id = result_id_q;

	assign new_lvl = (task_level == 2'd3) ? tpsch_pkg::LVL_DRIVER : task_level;
	assign new_id = 8'(count_q) + tpsch_pkg::FIRST_ID;
	assign tbl_we = accept && (command == tpsch_pkg::CMD_CREATE) && (count_q < MAX_C);
	assign hit = (state_q == S_CMP) && (tbl_rdata[9:2] == key_q);
	assign hit_idx = idx_q[IW-1:0];

	always_comb begin
		push_en = 1'b0;
		push_lvl = new_lvl;
		push_data = new_id;
		if (tbl_we) begin
			push_en = 1'b1;
		end else if (hit && (purpose_q != tpsch_pkg::WALK_POP) && !mark_q[hit_idx]) begin
			push_en = 1'b1;
			push_lvl = tbl_rdata[1:0];
			push_data = key_q;
		end
	end

	tpsch_ram #(.WIDTH(10), .DEPTH(MAX_TASKS)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (count_q[IW-1:0]),
		.wdata ({new_id, new_lvl}),
		.raddr (idx_q[IW-1:0]),
		.rdata (tbl_rdata)
	);

	for (genvar g = 0; g < 3; g++) begin : g_lane
		assign fifo_ctl[g].push = push_en && (push_lvl == 2'(g));
		assign fifo_ctl[g].pop = (state_q == S_POPD) && (sel_q == 2'(g));
		tpsch_fifo #(.DEPTH(MAX_TASKS)) u_fifo (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (fifo_ctl[g]),
			.push_data (push_data),
			.head_data (fifo_head[g]),
			.sts       (fifo_sts[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			purpose_q <= tpsch_pkg::WALK_ENQ;
			key_q <= '0;
			idx_q <= '0;
			count_q <= '0;
			running_q <= '0;
			enable_q <= 1'b1;
			mark_q <= '0;
			sel_q <= tpsch_pkg::LVL_APP;
			pend_status_q <= tpsch_pkg::ST_OK;
			pend_id_q <= '0;
			out_valid_q <= 1'b0;
			status_q <= tpsch_pkg::ST_OK;
			result_id_q <= '0;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_status_q <= tpsch_pkg::ST_OK;
						pend_id_q <= '0;
						idx_q <= '0;
						state_q <= S_DONE;
						unique case (command)
							tpsch_pkg::CMD_CREATE: begin
								if (count_q < MAX_C) begin
									mark_q[count_q[IW-1:0]] <= 1'b1;
									count_q <= count_q + CW'(1);
									pend_id_q <= new_id;
								end else begin
									pend_status_q <= tpsch_pkg::ST_FULL;
								end
							end
							tpsch_pkg::CMD_ENQUEUE: begin
								if (task_id < 16'(tpsch_pkg::FIRST_ID)) begin
									pend_status_q <= tpsch_pkg::ST_RESERVED;
								end else if (task_id[15:8] != '0) begin
									pend_status_q <= tpsch_pkg::ST_UNKNOWN;
								end else begin
									key_q <= task_id[7:0];
									purpose_q <= tpsch_pkg::WALK_ENQ;
									state_q <= S_SEEK;
								end
							end
							tpsch_pkg::CMD_SWITCH: begin
								if (!enable_q) begin
									pend_status_q <= tpsch_pkg::ST_DISABLED;
									pend_id_q <= running_q;
								end else if (running_q != '0 && !yielding) begin
									key_q <= running_q;
									purpose_q <= tpsch_pkg::WALK_REQ;
									state_q <= S_SEEK;
								end else begin
									state_q <= S_SELECT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SEEK: begin
					if (idx_q >= count_q) begin
						priority case (purpose_q)
							tpsch_pkg::WALK_ENQ: begin
								pend_status_q <= tpsch_pkg::ST_UNKNOWN;
								state_q <= S_DONE;
							end
							tpsch_pkg::WALK_REQ: begin
								state_q <= S_SELECT;
							end
							default: begin
								running_q <= key_q;
								pend_id_q <= key_q;
								state_q <= S_DONE;
							end
						endcase
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (hit) begin
						priority case (purpose_q)
							tpsch_pkg::WALK_ENQ: begin
								mark_q[hit_idx] <= 1'b1;
								state_q <= S_DONE;
							end
							tpsch_pkg::WALK_REQ: begin
								mark_q[hit_idx] <= 1'b1;
								state_q <= S_SELECT;
							end
							default: begin
								mark_q[hit_idx] <= 1'b0;
								running_q <= key_q;
								pend_id_q <= key_q;
								state_q <= S_DONE;
							end
						endcase
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_SEEK;
					end
				end
				S_SELECT: begin
					idx_q <= '0;
					purpose_q <= tpsch_pkg::WALK_POP;
					if (!fifo_sts[2].empty) begin
						sel_q <= tpsch_pkg::LVL_DRIVER;
						state_q <= S_POPD;
					end else if (!fifo_sts[1].empty) begin
						sel_q <= tpsch_pkg::LVL_GRAPHIC;
						state_q <= S_POPD;
					end else if (!fifo_sts[0].empty) begin
						sel_q <= tpsch_pkg::LVL_APP;
						state_q <= S_POPD;
					end else begin
						running_q <= '0;
						pend_id_q <= '0;
						state_q <= S_DONE;
					end
				end
				S_POPD: begin
					key_q <= fifo_head[sel_q];
					state_q <= S_SEEK;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q <= pend_status_q;
						result_id_q <= pend_id_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/tpsch_checker.sv @@
`default_nettype none
module tpsch_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  command,
	input wire logic [15:0] task_id,
	input wire logic [1:0]  task_level,
	input wire logic        yielding,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [7:0]  result_id,
	input wire logic        cfg_we,
	input wire logic        cfg_wdata
);

	// The sequencer leaves the idle state after every input transfer.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready stayed high after a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_id))
		else $error("stalled result changed");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= tpsch_pkg::ST_DISABLED)
		else $error("status code out of range");

	// Refused commands other than a disabled switch never carry an id.
	a_err_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == tpsch_pkg::ST_RESERVED || status == tpsch_pkg::ST_UNKNOWN
		|| status == tpsch_pkg::ST_FULL) |-> result_id == '0)
		else $error("error result carries an id");

endmodule

bind three_level_priority_task_scheduler_core tpsch_checker u_tpsch_checker (.*);
`default_nettype wire

@@ test/tb_three_level_priority_task_scheduler_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_three_level_priority_task_scheduler_core;

	localparam int TASKS = 16;
	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [15:0] task_id;
	logic [1:0]  task_level;
	logic        yielding;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [7:0]  result_id;
	logic        cfg_we;
	logic        cfg_wdata;

	three_level_priority_task_scheduler_core #(.MAX_TASKS(TASKS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .task_id(task_id), .task_level(task_level), .yielding(yielding),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_id(result_id),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	typedef struct {
		logic [2:0] st;
		logic [7:0] id;
	} sched_reply_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] tid;
		logic [1:0]  lvl;
		logic        yld;
		logic        known;
		logic [2:0]  st;
		logic [7:0]  id;
	} sched_row_t;

	logic [7:0]   task_ids [TASKS];
	logic [1:0]   task_lvls [TASKS];
	logic         in_queue [TASKS];
	int           num_tasks;
	logic [7:0]   now_running;
	logic         sw_enable;
	logic [7:0]   ready_q [3][$];
	sched_reply_t pending_replies[$];
	int           errors;
	int           idle_cycles;
	logic         hold_rx;
	logic         done;

	function automatic int slot_of(int ident);
		if (ident < tpsch_pkg::FIRST_ID)
			return -1;
		for (int i = 0; i < num_tasks; i++)
			if (task_ids[i] == ident)
				return i;
		return -1;
	endfunction

	function automatic void mark_ready(int idx);
		if (in_queue[idx])
			return;
		in_queue[idx] = 1'b1;
		if (ready_q[task_lvls[idx]].size() < TASKS)
			ready_q[task_lvls[idx]].push_back(task_ids[idx]);
	endfunction

	function automatic sched_reply_t schedule(logic [1:0] cmd, logic [15:0] tid,
			logic [1:0] lvl, logic yld);
		sched_reply_t r;
		int cand;
		int idx;
		logic [7:0] nxt;
		r.st = tpsch_pkg::ST_OK;
		r.id = 8'd0;
		if (cmd == tpsch_pkg::CMD_CREATE) begin
			if (num_tasks >= TASKS) begin
				r.st = tpsch_pkg::ST_FULL;
			end else begin
				cand = tpsch_pkg::FIRST_ID;
				while (slot_of(cand) >= 0)
					cand++;
				task_ids[num_tasks] = cand[7:0];
				task_lvls[num_tasks] = (lvl > tpsch_pkg::LVL_DRIVER) ?
					tpsch_pkg::LVL_DRIVER : lvl;
				in_queue[num_tasks] = 1'b0;
				num_tasks++;
				mark_ready(num_tasks - 1);
				r.id = cand[7:0];
			end
		end else if (cmd == tpsch_pkg::CMD_ENQUEUE) begin
			if (tid < tpsch_pkg::FIRST_ID) begin
				r.st = tpsch_pkg::ST_RESERVED;
			end else begin
				idx = slot_of(int'(tid));
				if (idx < 0)
					r.st = tpsch_pkg::ST_UNKNOWN;
				else
					mark_ready(idx);
			end
		end else if (cmd == tpsch_pkg::CMD_SWITCH) begin
			if (!sw_enable) begin
				r.st = tpsch_pkg::ST_DISABLED;
				r.id = now_running;
			end else begin
				if (now_running != 0 && !yld) begin
					idx = slot_of(int'(now_running));
					if (idx >= 0)
						mark_ready(idx);
				end
				nxt = 8'd0;
				for (int k = 2; k >= 0 && nxt == 0; k--) begin
					while (ready_q[k].size() != 0 && nxt == 0) begin
						idx = slot_of(int'(ready_q[k].pop_front()));
						if (idx >= 0) begin
							in_queue[idx] = 1'b0;
							nxt = task_ids[idx];
						end
					end
				end
				now_running = nxt;
				r.id = nxt;
			end
		end
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_command(logic [1:0] cmd, logic [15:0] tid, logic [1:0] lvl,
			logic yld, logic known, logic [2:0] st, logic [7:0] id);
		sched_reply_t r;
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 3))
				@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		task_id <= tid;
		task_level <= lvl;
		yielding <= yld;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = schedule(cmd, tid, lvl, yld);
		if (known && r.st != st) begin
			$error("status expected %0d actual %0d", st, r.st);
			errors++;
		end
		if (known && r.id != id) begin
			$error("result_id expected %0d actual %0d", id, r.id);
			errors++;
		end
		pending_replies.push_back(r);
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (4 * TASKS + 20)
			@(posedge clk);
	endtask

	task automatic write_enable(logic val);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sw_enable = val;
	endtask

	task automatic random_command();
		int pick;
		logic [15:0] tid;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			tid = 16'($urandom_range(0, 2));
		else if (pick < 20)
			tid = 16'($urandom);
		else
			tid = 16'($urandom_range(3, 24));
		pick = $urandom_range(0, 99);
		if (pick < 15 && num_tasks >= TASKS)
			pick = 50;
		if (pick < 20)
			send_command(tpsch_pkg::CMD_CREATE, 16'($urandom), 2'($urandom), 1'($urandom),
				1'b0, tpsch_pkg::ST_OK, 8'd0);
		else if (pick < 55)
			send_command(tpsch_pkg::CMD_ENQUEUE, tid, 2'($urandom), 1'($urandom),
				1'b0, tpsch_pkg::ST_OK, 8'd0);
		else if (pick < 97)
			send_command(tpsch_pkg::CMD_SWITCH, 16'($urandom), 2'($urandom), 1'($urandom),
				1'b0, tpsch_pkg::ST_OK, 8'd0);
		else
			send_command(2'd3, 16'($urandom), 2'($urandom), 1'($urandom),
				1'b0, tpsch_pkg::ST_OK, 8'd0);
	endtask

	sched_row_t rows [] = '{
		'{tpsch_pkg::CMD_SWITCH, 16'h0000, tpsch_pkg::LVL_APP, 1'b0, 1'b1,
			tpsch_pkg::ST_OK, 8'd0},
		'{tpsch_pkg::CMD_ENQUEUE, 16'd3, tpsch_pkg::LVL_APP, 1'b0, 1'b1,
			tpsch_pkg::ST_UNKNOWN, 8'd0},
		'{tpsch_pkg::CMD_CREATE, 16'hffff, tpsch_pkg::LVL_APP, 1'b0, 1'b1,
			tpsch_pkg::ST_OK, 8'd3},
		'{tpsch_pkg::CMD_CREATE, 16'h0000, tpsch_pkg::LVL_GRAPHIC, 1'b1, 1'b1,
			tpsch_pkg::ST_OK, 8'd4},
		'{tpsch_pkg::CMD_CREATE, 16'h0000, 2'd3, 1'b0, 1'b1,
			tpsch_pkg::ST_OK, 8'd5},
		'{tpsch_pkg::CMD_CREATE, 16'h0000, tpsch_pkg::LVL_DRIVER, 1'b0, 1'b1,
			tpsch_pkg::ST_OK, 8'd6},
		'{tpsch_pkg::CMD_ENQUEUE, 16'd0, tpsch_pkg::LVL_APP, 1'b0, 1'b1,
			tpsch_pkg::ST_RESERVED, 8'd0},
		'{tpsch_pkg::CMD_ENQUEUE, 16'd1, tpsch_pkg::LVL_APP, 1'b0, 1'b1,
			tpsch_pkg::ST_RESERVED, 8'd0},
		'{tpsch_pkg::CMD_ENQUEUE, 16'd2, tpsch_pkg::LVL_APP, 1'b0, 1'b1,
			tpsch_pkg::ST_RESERVED, 8'd0},
		'{tpsch_pkg::CMD_ENQUEUE, 16'hffff, tpsch_pkg::LVL_APP, 1'b0, 1'b1,
			tpsch_pkg::ST_UNKNOWN, 8'd0},
		'{tpsch_pkg::CMD_ENQUEUE, 16'h0103, tpsch_pkg::LVL_APP, 1'b0, 1'b1,
			tpsch_pkg::ST_UNKNOWN, 8'd0},
		'{tpsch_pkg::CMD_ENQUEUE, 16'd255, tpsch_pkg::LVL_APP, 1'b0, 1'b1,
			tpsch_pkg::ST_UNKNOWN, 8'd0},
		'{tpsch_pkg::CMD_ENQUEUE, 16'd3, tpsch_pkg::LVL_APP, 1'b0, 1'b1,
			tpsch_pkg::ST_OK, 8'd0},
		'{tpsch_pkg::CMD_SWITCH, 16'h0000, tpsch_pkg::LVL_APP, 1'b0, 1'b1,
			tpsch_pkg::ST_OK, 8'd5},
		'{tpsch_pkg::CMD_SWITCH, 16'h0000, tpsch_pkg::LVL_APP, 1'b0, 1'b0,
			tpsch_pkg::ST_OK, 8'd0},
		'{tpsch_pkg::CMD_SWITCH, 16'h0000, tpsch_pkg::LVL_APP, 1'b1, 1'b0,
			tpsch_pkg::ST_OK, 8'd0},
		'{2'd3, 16'hffff, 2'd3, 1'b1, 1'b1,
			tpsch_pkg::ST_OK, 8'd0},
		'{tpsch_pkg::CMD_SWITCH, 16'h0000, tpsch_pkg::LVL_APP, 1'b0, 1'b0,
			tpsch_pkg::ST_OK, 8'd0},
		'{tpsch_pkg::CMD_SWITCH, 16'h0000, tpsch_pkg::LVL_APP, 1'b1, 1'b0,
			tpsch_pkg::ST_OK, 8'd0}
	};

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = tpsch_pkg::CMD_CREATE;
		task_id = 16'd0;
		task_level = tpsch_pkg::LVL_APP;
		yielding = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		num_tasks = 0;
		now_running = 8'd0;
		sw_enable = 1'b1;
		for (int i = 0; i < TASKS; i++)
			in_queue[i] = 1'b0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_enable(1'b1);
		foreach (rows[i])
			send_command(rows[i].cmd, rows[i].tid, rows[i].lvl, rows[i].yld,
				rows[i].known, rows[i].st, rows[i].id);
		drain_replies();
		write_enable(1'b0);
		send_command(tpsch_pkg::CMD_SWITCH, 16'd0, tpsch_pkg::LVL_APP, 1'b0, 1'b0,
			tpsch_pkg::ST_OK, 8'd0);
		send_command(tpsch_pkg::CMD_CREATE, 16'd0, tpsch_pkg::LVL_APP, 1'b0, 1'b0,
			tpsch_pkg::ST_OK, 8'd0);
		send_command(tpsch_pkg::CMD_SWITCH, 16'd0, tpsch_pkg::LVL_APP, 1'b1, 1'b0,
			tpsch_pkg::ST_OK, 8'd0);
		drain_replies();
		write_enable(1'b1);
		// The table fills up here, so the full case is reached early.
		while (num_tasks < TASKS)
			send_command(tpsch_pkg::CMD_CREATE, 16'd0, 2'($urandom), 1'b0, 1'b0,
				tpsch_pkg::ST_OK, 8'd0);
		send_command(tpsch_pkg::CMD_CREATE, 16'd0, tpsch_pkg::LVL_APP, 1'b0, 1'b1,
			tpsch_pkg::ST_FULL, 8'd0);
		for (int phase = 0; phase < 4; phase++) begin
			repeat (120)
				random_command();
			drain_replies();
			write_enable(phase[0]);
		end
		drain_replies();
		done = 1'b1;
	end

	initial begin
		hold_rx = 1'b0;
		repeat (800)
			@(posedge clk);
		hold_rx = 1'b1;
		repeat (600)
			@(posedge clk);
		hold_rx = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !hold_rx && ($urandom_range(0, 3) != 0 || $urandom_range(0, 1) == 0);
		end
	end

	always @(posedge clk) begin
		sched_reply_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				$error("result with nothing outstanding: status %0d id %0d", status, result_id);
				errors++;
			end else begin
				e = pending_replies.pop_front();
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
				if (result_id !== e.id) begin
					$error("result_id expected %0d actual %0d", e.id, result_id);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		done = 1'b0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (done) begin
				if (errors == 0 && pending_replies.size() == 0)
					$display("three_level_priority_task_scheduler_core verification clean");
				else
					$display("three_level_priority_task_scheduler_core verification failed");
				$finish;
			end else if (idle_cycles >= WATCHDOG) begin
				$display("three_level_priority_task_scheduler_core verification failed");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire
